// ===== hdl/hjb_pkg.sv =====
`default_nettype none
package hjb_pkg;

    localparam int KEY_W       = 31;
    localparam int OFFSET_BITS = 24;
    localparam int MOD_W       = 12;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int POOL_DEPTH_DEF  = 1024;
    localparam int MAX_CHAIN_DEF   = 64;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_PROBE  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MISS       = 2'd1;
    localparam logic [1:0] ST_POOL_FULL  = 2'd2;
    localparam logic [1:0] ST_CHAIN_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]             op;
        logic [KEY_W-1:0]       key;
        logic [OFFSET_BITS-1:0] offset;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [OFFSET_BITS-1:0] match_offset;
        logic                   last;
    } out_item_t;

    typedef enum logic [3:0] {
        CS_SWEEP_RST,
        CS_SWEEP_CLR,
        CS_IDLE,
        CS_DIV,
        CS_REDUCE,
        CS_CHK,
        CS_WALK,
        CS_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic load_b;
        logic reduce_step;
        logic sweep_step;
        logic emit_clear;
        logic ins_resolve;
        logic probe_head;
        logic walk_step;
        logic finish;
    } hjb_cmd_t;

    typedef struct packed {
        logic [1:0] in_op;
        logic [1:0] op;
        logic       div_done;
        logic       b_in_range;
        logic       sweep_last;
        logic       used;
        logic       chain_more;
        logic       walk_last;
    } hjb_stat_t;

endpackage
`default_nettype wire

// ===== hdl/hjb_div.sv =====
`default_nettype none
module hjb_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [hjb_pkg::KEY_W-1:0] dividend,
    input  wire logic [hjb_pkg::MOD_W-1:0] divisor,
    output logic                          done,
    output logic [hjb_pkg::MOD_W-1:0]     remainder
);
    import hjb_pkg::*;

    localparam int CNT_W = $clog2(KEY_W);

    logic [MOD_W-1:0] rem_reg, rem_next;
    logic [KEY_W-1:0] dvd_reg;
    logic [MOD_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [MOD_W:0]   trial;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial = {rem_reg, dvd_reg[KEY_W-1]};
        if (trial >= {1'b0, dsr_reg})
            rem_next = MOD_W'(trial - {1'b0, dsr_reg});
        else
            rem_next = trial[MOD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(KEY_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[KEY_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ===== hdl/hjb_ctrl.sv =====
`default_nettype none
module hjb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire hjb_pkg::hjb_stat_t stat,
    output hjb_pkg::hjb_cmd_t      cmd,
    output logic                   busy
);
    import hjb_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_SWEEP_RST;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy       = (state_reg != CS_IDLE);
        case (state_reg)
            CS_SWEEP_RST:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                    state_next = CS_IDLE;
            end
            CS_SWEEP_CLR:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.emit_clear = 1'b1;
                    state_next     = CS_IDLE;
                end
            end
            CS_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (stat.in_op == OP_CLEAR)
                        state_next = CS_SWEEP_CLR;
                    else if (stat.in_op == OP_INSERT || stat.in_op == OP_PROBE)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = CS_DIV;
                    end
                end
            end
            CS_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.load_b = 1'b1;
                    state_next = CS_REDUCE;
                end
            end
            CS_REDUCE:
            begin
                if (!stat.b_in_range)
                    cmd.reduce_step = 1'b1;
                else
                    state_next = CS_CHK;
            end
            CS_CHK:
            begin
                if (stat.op == OP_INSERT)
                begin
                    cmd.ins_resolve = 1'b1;
                    state_next      = CS_IDLE;
                end
                else
                begin
                    cmd.probe_head = 1'b1;
                    if (!stat.used)
                        state_next = CS_IDLE;
                    else if (stat.chain_more)
                        state_next = CS_WALK;
                    else
                        state_next = CS_FIN;
                end
            end
            CS_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                    state_next = CS_FIN;
            end
            CS_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/hjb_datapath.sv =====
`default_nettype none
module hjb_datapath #(
    parameter int TABLE_DEPTH = hjb_pkg::TABLE_DEPTH_DEF,
    parameter int POOL_DEPTH  = hjb_pkg::POOL_DEPTH_DEF,
    parameter int MAX_CHAIN   = hjb_pkg::MAX_CHAIN_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire hjb_pkg::in_item_t        item,
    input  wire logic                     wr_en,
    input  wire logic [hjb_pkg::MOD_W-1:0] wr_data,
    input  wire hjb_pkg::hjb_cmd_t        cmd,
    output hjb_pkg::hjb_stat_t            stat,
    output logic                          result_valid,
    output hjb_pkg::out_item_t            result
);
    import hjb_pkg::*;

    localparam int TIDX_W = $clog2(TABLE_DEPTH);
    localparam int PIDX_W = $clog2(POOL_DEPTH);
    localparam int FILL_W = $clog2(POOL_DEPTH + 1);
    localparam int LEN_W  = $clog2(MAX_CHAIN + 1);

    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic [OFFSET_BITS-1:0] off;
        logic [PIDX_W-1:0]      nxt;
        logic [PIDX_W-1:0]      tail;
        logic [LEN_W-1:0]       len;
    } bkt_t;

    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic [OFFSET_BITS-1:0] off;
    } pent_t;

    // memories
    logic  used_mem [TABLE_DEPTH];
    bkt_t  bkt_mem  [TABLE_DEPTH];
    pent_t pd_mem   [POOL_DEPTH];
    logic [PIDX_W-1:0] pn_mem [POOL_DEPTH];

    logic              used_rd;
    bkt_t              bkt_rd;
    pent_t             pd_rd;
    logic [PIDX_W-1:0] pn_rd;

    logic [MOD_W-1:0]       cfg_reg;
    logic [1:0]             op_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [MOD_W-1:0]       b_reg;
    logic [TIDX_W-1:0]      sweep_reg;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [LEN_W-1:0]       cnt_reg;
    logic                   pend_valid_reg;
    logic [OFFSET_BITS-1:0] pend_off_reg;
    logic                   res_valid_reg;
    out_item_t              res_reg;

    logic              div_done;
    logic [MOD_W-1:0]  div_rem;
    logic [MOD_W-1:0]  modulus;
    logic [TIDX_W-1:0] bidx;
    logic [PIDX_W-1:0] pr_addr;
    logic [PIDX_W-1:0] slot;

    logic              used_we, used_wd;
    logic [TIDX_W-1:0] used_wa;
    logic              bkt_we;
    bkt_t              bkt_wd;
    logic              pd_we, pn_we;
    logic              emit_v;
    out_item_t         emit_d;
    logic              hit;

    // odd modulus: an even count gets one added
    assign modulus = cfg_reg | MOD_W'(1);
    assign bidx    = TIDX_W'(b_reg);
    assign pr_addr = cmd.walk_step ? pn_rd : bkt_rd.nxt;
    assign slot    = PIDX_W'(fill_reg);
    assign hit     = (pd_rd.key == key_reg);

    hjb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (item.key),
        .divisor   (modulus),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        used_we   = 1'b0;
        used_wa   = bidx;
        used_wd   = 1'b0;
        bkt_we    = 1'b0;
        bkt_wd    = bkt_rd;
        pd_we     = 1'b0;
        pn_we     = 1'b0;
        emit_v    = 1'b0;
        emit_d    = '{status: ST_OK, match_offset: '0, last: 1'b1};
        fill_next = fill_reg;

        if (cmd.sweep_step)
        begin
            used_we = 1'b1;
            used_wa = sweep_reg;
        end

        if (cmd.emit_clear)
        begin
            emit_v    = 1'b1;
            fill_next = '0;
        end

        if (cmd.ins_resolve)
        begin
            emit_v = 1'b1;
            if (!used_rd)
            begin
                used_we = 1'b1;
                used_wd = 1'b1;
                bkt_we  = 1'b1;
                bkt_wd  = '{key: key_reg, off: off_reg, nxt: '0, tail: '0, len: LEN_W'(1)};
            end
            else if (bkt_rd.len >= LEN_W'(MAX_CHAIN))
                emit_d.status = ST_CHAIN_FULL;
            else if (fill_reg >= FILL_W'(POOL_DEPTH))
                emit_d.status = ST_POOL_FULL;
            else
            begin
                pd_we = 1'b1;
                pn_we = (bkt_rd.len != LEN_W'(1));
                bkt_we = 1'b1;
                if (bkt_rd.len == LEN_W'(1))
                    bkt_wd.nxt = slot;
                bkt_wd.tail = slot;
                bkt_wd.len  = bkt_rd.len + LEN_W'(1);
                fill_next   = fill_reg + FILL_W'(1);
            end
        end

        if (cmd.probe_head && !used_rd)
        begin
            emit_v        = 1'b1;
            emit_d.status = ST_MISS;
        end

        // a match is held back until the next match or the finish so that its last mark is known
        if (cmd.walk_step && hit && pend_valid_reg)
        begin
            emit_v = 1'b1;
            emit_d = '{status: ST_OK, match_offset: pend_off_reg, last: 1'b0};
        end

        if (cmd.finish)
        begin
            emit_v = 1'b1;
            if (pend_valid_reg)
                emit_d.match_offset = pend_off_reg;
            else
                emit_d.status = ST_MISS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
            used_mem[used_wa] <= used_wd;
        used_rd <= used_mem[bidx];
        if (bkt_we)
            bkt_mem[bidx] <= bkt_wd;
        bkt_rd <= bkt_mem[bidx];
    end

    always_ff @(posedge clk)
    begin
        if (pd_we)
            pd_mem[slot] <= '{key: key_reg, off: off_reg};
        pd_rd <= pd_mem[pr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pn_we)
            pn_mem[bkt_rd.tail] <= slot;
        pn_rd <= pn_mem[pr_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '0;
            sweep_reg      <= '0;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                cfg_reg <= wr_data;
            if (cmd.sweep_step)
                sweep_reg <= stat.sweep_last ? '0 : sweep_reg + TIDX_W'(1);
            fill_reg      <= fill_next;
            res_valid_reg <= emit_v;
            if (cmd.probe_head)
                pend_valid_reg <= used_rd && (bkt_rd.key == key_reg);
            else if (cmd.walk_step && hit)
                pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= item.op;
            key_reg <= item.key;
            off_reg <= item.offset;
        end
        if (cmd.load_b)
            b_reg <= div_rem;
        else if (cmd.reduce_step)
            b_reg <= b_reg - MOD_W'(TABLE_DEPTH);
        if (cmd.probe_head)
        begin
            pend_off_reg <= bkt_rd.off;
            cnt_reg      <= bkt_rd.len - LEN_W'(1);
        end
        else if (cmd.walk_step)
        begin
            cnt_reg <= cnt_reg - LEN_W'(1);
            if (hit)
                pend_off_reg <= pd_rd.off;
        end
        if (emit_v)
            res_reg <= emit_d;
    end

    always_comb
    begin
        stat            = '0;
        stat.in_op      = item.op;
        stat.op         = op_reg;
        stat.div_done   = div_done;
        stat.b_in_range = (32'(b_reg) < TABLE_DEPTH);
        stat.sweep_last = (sweep_reg == TIDX_W'(TABLE_DEPTH - 1));
        stat.used       = used_rd;
        stat.chain_more = (bkt_rd.len > LEN_W'(1));
        stat.walk_last  = (cnt_reg == LEN_W'(1));
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire

// ===== hdl/hash_join_build_probe_top.sv =====
`default_nettype none
// hash-join table engine: chained hash table for build and probe
//
// input: an item transfers at a clock edge with start high and busy low.
//   op clear empties the table, op insert stores key and offset, op probe
//   looks a key up; op code three is taken and dropped with no result.
// output: every result shows for exactly one cycle with result_valid high;
//   the receiver cannot stall, so results never wait. a probe gives one
//   result per matching entry in insertion order, last set on the final one,
//   or a single no-match result.
// config: wr_en writes build_tuple_count (wr_data); the user must write it
//   only while idle, the block itself does not enforce it. the bucket is
//   key mod (count made odd), reduced mod TABLE_DEPTH.
// timing: one item at a time. the key mod is a bit-serial divider, 31 steps
//   then done. an insert, or a probe of a free bucket, keeps busy high until
//   its result, which shows in the cycle busy drops; any other probe walks
//   any entries beyond the bucket head and ends in a finish state. when the
//   modulus exceeds the table, the remainder is reduced by TABLE_DEPTH steps.
//   a clear sweeps the bucket marks, one per cycle, then gives its result.
// reset: the same sweep runs after reset with busy high; configuration
//   writes are taken meanwhile.
module hash_join_build_probe_top #(
    parameter int TABLE_DEPTH = hjb_pkg::TABLE_DEPTH_DEF,
    parameter int POOL_DEPTH  = hjb_pkg::POOL_DEPTH_DEF,
    parameter int MAX_CHAIN   = hjb_pkg::MAX_CHAIN_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire hjb_pkg::in_item_t        item,
    output logic                          busy,
    input  wire logic                     wr_en,
    input  wire logic [hjb_pkg::MOD_W-1:0] wr_data,
    output logic                          result_valid,
    output hjb_pkg::out_item_t            result
);
    import hjb_pkg::*;

    hjb_cmd_t  cmd;
    hjb_stat_t stat;

    // sequencer: walks each item through hash, lookup and chain walk
    hjb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // divider, bucket and pool memories, result register
    hjb_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .POOL_DEPTH  (POOL_DEPTH),
        .MAX_CHAIN   (MAX_CHAIN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .wr_en        (wr_en),
        .wr_data      (wr_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

    // results only come out of work started by a transfer
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without active item");

    // an item that asks for work keeps the block busy
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.op == OP_CLEAR || item.op == OP_INSERT ||
         item.op == OP_PROBE)) |=> busy)
        else $error("item taken without going busy");

    // anything but a match carries a zero offset
    a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_OK) |-> (result.match_offset == '0))
        else $error("non-match result with offset");

endmodule
`default_nettype wire
